// ----- hw/rtl/lcs_pkg.sv -----
// shared types and constants for the lcs length engine
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int LCS_MAX_LEN = 64;
  localparam int CH_W        = 8;
  localparam int LEN_OUT_W   = 7;

  typedef logic [1:0] req_t;

  localparam req_t REQ_LOAD = 2'd0;
  localparam req_t REQ_CMP  = 2'd1;
  localparam req_t REQ_FIN  = 2'd2;

  // token control that walks down the cell chain
  typedef struct packed {
    logic valid;
    logic fin;
  } lcs_tok_t;

endpackage

// ----- hw/rtl/lcs_cell.sv -----
// one column cell of the lcs chain: stored char, dp value, token stage
`timescale 1ns / 1ps

module lcs_cell
  import lcs_pkg::*;
#(
  parameter int VAL_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_en,
  input  logic [CH_W-1:0]  load_ch,
  input  logic             next_active,
  input  lcs_tok_t         tok_in,
  input  logic [CH_W-1:0]  ch_in,
  input  logic [VAL_W-1:0] left_in,
  input  logic [VAL_W-1:0] diag_in,
  input  logic [VAL_W-1:0] res_in,
  output logic             active,
  output lcs_tok_t         tok_out,
  output logic [CH_W-1:0]  ch_out,
  output logic [VAL_W-1:0] left_out,
  output logic [VAL_W-1:0] diag_out,
  output logic [VAL_W-1:0] res_out
);

  logic [CH_W-1:0]  stored;
  logic [VAL_W-1:0] row;
  logic [VAL_W-1:0] row_next;
  logic             active_next;
  logic [VAL_W-1:0] cmp_val;

  always_comb begin
    if (ch_in == stored) begin
      cmp_val = diag_in + VAL_W'(1);
    end else if (row > left_in) begin
      cmp_val = row;
    end else begin
      cmp_val = left_in;
    end
  end

  always_comb begin
    row_next    = row;
    active_next = active;
    if (load_en) begin
      active_next = 1'b1;
    end
    if (tok_in.valid) begin
      if (tok_in.fin) begin
        row_next    = '0;
        active_next = 1'b0;
      end else if (active) begin
        row_next = cmp_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      active  <= 1'b0;
      tok_out <= '0;
    end else begin
      row     <= row_next;
      active  <= active_next;
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      stored <= load_ch;
    end
    ch_out   <= ch_in;
    left_out <= (active && !tok_in.fin) ? cmp_val : '0;
    diag_out <= row;
    // the last loaded column drops its value into the finish token
    res_out  <= (tok_in.fin && active && !next_active) ? row : res_in;
  end

endmodule

// ----- hw/rtl/lcs_length_engine.sv -----
// top level of the lcs length engine: request decode, cell chain, result register
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------
//  request  | req_valid, req_stall | req_type, ch
//  result   | res_valid, res_stall | lcs_length, misuse_flag
//
// load and compare requests are taken one per cycle while req_stall is low;
// a compare moves through the MAX_LEN cells one cell per cycle, so compares
// overlap in the chain. a finish walks the whole chain and its result is
// registered at the end; req_stall stays high from the finish until the
// result is taken. reset clears every cell at once, no clearing pass.
`timescale 1ns / 1ps

module lcs_length_engine
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = LCS_MAX_LEN
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           req_type,
  input  logic [CH_W-1:0]      ch,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [LEN_OUT_W-1:0] lcs_length,
  output logic                 misuse_flag
);

  localparam int VAL_W = $clog2(MAX_LEN + 1);

  logic [VAL_W-1:0] count;
  logic             started;
  logic             dropped;
  logic             busy;
  logic             flag_hold;

  logic             accept;
  logic             load_fire;
  lcs_tok_t         head_tok;

  lcs_tok_t         tok   [0:MAX_LEN];
  logic [CH_W-1:0]  tch   [0:MAX_LEN];
  logic [VAL_W-1:0] tleft [0:MAX_LEN];
  logic [VAL_W-1:0] tdiag [0:MAX_LEN];
  logic [VAL_W-1:0] tres  [0:MAX_LEN];
  logic [MAX_LEN-1:0] act;
  logic [MAX_LEN-1:0] load_en;

  logic [VAL_W+LEN_OUT_W-1:0] res_wide;

  assign req_stall = busy;
  assign accept    = req_valid && !busy;

  always_comb begin
    load_fire = 1'b0;
    head_tok  = '0;
    if (accept) begin
      unique case (req_type)
        REQ_LOAD: load_fire = !started && (count != VAL_W'(MAX_LEN));
        REQ_CMP:  head_tok.valid = 1'b1;
        REQ_FIN: begin
          head_tok.valid = 1'b1;
          head_tok.fin   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign tok[0]   = head_tok;
  assign tch[0]   = ch;
  assign tleft[0] = '0;
  assign tdiag[0] = '0;
  assign tres[0]  = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic nxt;
    if (j == MAX_LEN - 1) begin : g_end
      assign nxt = 1'b0;
    end else begin : g_mid
      assign nxt = act[j+1];
    end
    assign load_en[j] = load_fire && (count == VAL_W'(j));

    lcs_cell #(
      .VAL_W (VAL_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .load_en     (load_en[j]),
      .load_ch     (ch),
      .next_active (nxt),
      .tok_in      (tok[j]),
      .ch_in       (tch[j]),
      .left_in     (tleft[j]),
      .diag_in     (tdiag[j]),
      .res_in      (tres[j]),
      .active      (act[j]),
      .tok_out     (tok[j+1]),
      .ch_out      (tch[j+1]),
      .left_out    (tleft[j+1]),
      .diag_out    (tdiag[j+1]),
      .res_out     (tres[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      started <= 1'b0;
      dropped <= 1'b0;
      busy    <= 1'b0;
    end else begin
      if (accept) begin
        unique case (req_type)
          REQ_LOAD: begin
            if (load_fire) begin
              count <= count + VAL_W'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
          REQ_CMP: started <= 1'b1;
          REQ_FIN: begin
            count   <= '0;
            started <= 1'b0;
            dropped <= 1'b0;
            busy    <= 1'b1;
          end
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req_type == REQ_FIN)) begin
      flag_hold <= dropped;
    end
  end

  assign res_wide = {{LEN_OUT_W{1'b0}}, tres[MAX_LEN]};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tok[MAX_LEN].valid && tok[MAX_LEN].fin) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[MAX_LEN].valid && tok[MAX_LEN].fin) begin
      lcs_length  <= res_wide[LEN_OUT_W-1:0];
      misuse_flag <= flag_hold;
    end
  end

endmodule

// ----- hw/rtl/lcs_chk.sv -----
// port-level checks for the lcs length engine, bound to the top level
`timescale 1ns / 1ps

module lcs_chk
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = LCS_MAX_LEN
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic [1:0]           req_type,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic [LEN_OUT_W-1:0] lcs_length,
  input logic                 misuse_flag
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(lcs_length) && $stable(misuse_flag))
    else $error("result payload changed while stalled");

  a_fin_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req_type == REQ_FIN) |=> req_stall)
    else $error("request taken while finish in flight");

  a_res_frees: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall |=> !req_stall && !res_valid)
    else $error("engine still busy after result taken");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(lcs_length) <= 32'(MAX_LEN)))
    else $error("lcs length beyond capacity");

endmodule

bind lcs_length_engine lcs_chk #(
  .MAX_LEN (MAX_LEN)
) u_lcs_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .req_type    (req_type),
  .res_valid   (res_valid),
  .res_stall   (res_stall),
  .lcs_length  (lcs_length),
  .misuse_flag (misuse_flag)
);

// ----- sim/tb_lcs_length_engine.sv -----
`timescale 1ns / 1ps
// self-checking bench for the lcs length engine: dp row predictor, directed and random strings

module tb_lcs_length_engine;
  import lcs_pkg::*;

  localparam req_t REQ_UNUSED   = 2'd3;
  localparam int   ITEM_TARGET  = 1950;
  localparam int   DRAIN_CYCLES = LCS_MAX_LEN + 16;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] len;
    logic                 flag;
  } lcs_result_t;

  class lcs_scoreboard;
    logic [CH_W-1:0]      stored_chars[LCS_MAX_LEN];
    logic [LEN_OUT_W-1:0] dp_row[LCS_MAX_LEN];
    int unsigned          stored_len;
    bit                   cmp_seen;
    bit                   load_dropped;
    lcs_result_t          expected_q[$];
    int                   errors;
    int                   checked;
    int                   flagged;

    function new();
      clear_state();
    endfunction

    function void clear_state();
      foreach (dp_row[j]) dp_row[j] = '0;
      stored_len   = 0;
      cmp_seen     = 1'b0;
      load_dropped = 1'b0;
    endfunction

    function void note_request(req_t kind, logic [CH_W-1:0] c);
      logic [LEN_OUT_W-1:0] diag, left, above, val;
      lcs_result_t          res;
      case (kind)
        REQ_LOAD: begin
          if (cmp_seen || stored_len >= LCS_MAX_LEN) begin
            load_dropped = 1'b1;
          end else begin
            stored_chars[stored_len] = c;
            stored_len++;
          end
        end
        REQ_CMP: begin
          cmp_seen = 1'b1;
          diag     = '0;
          left     = '0;
          // one dp row in place, diag holds the old value of the column to the left
          for (int j = 0; j < stored_len; j++) begin
            above = dp_row[j];
            if (stored_chars[j] == c) val = diag + 1'b1;
            else val = (above > left) ? above : left;
            diag      = above;
            left      = val;
            dp_row[j] = val;
          end
        end
        REQ_FIN: begin
          res.len  = (stored_len > 0) ? dp_row[stored_len-1] : '0;
          res.flag = load_dropped;
          expected_q.push_back(res);
          clear_state();
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [LEN_OUT_W-1:0] len, logic flag);
      lcs_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, lcs_length %0d misuse_flag %0d", $time, len, flag);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.flag) flagged++;
      if (len !== want.len) begin
        $display("%0t: lcs_length expected %0d actual %0d", $time, want.len, len);
        errors++;
      end
      if (flag !== want.flag) begin
        $display("%0t: misuse_flag expected %0d actual %0d", $time, want.flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [1:0]           req_type = REQ_LOAD;
  logic [CH_W-1:0]      ch = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [LEN_OUT_W-1:0] lcs_length;
  logic                 misuse_flag;

  lcs_scoreboard sb = new();

  int unsigned     tx_idle_pct = 33;
  int unsigned     rx_idle_pct = 52;
  int              sent = 0;
  bit              narrow_alpha;
  logic [CH_W-1:0] char_base;

  lcs_length_engine u_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .ch         (ch),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .lcs_length (lcs_length),
    .misuse_flag(misuse_flag)
  );

  always #1 clk = ~clk;

  // result side: random back-pressure, check on every taken result
  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    if (!rst && res_valid && !res_stall) sb.check_result(lcs_length, misuse_flag);
  end

  // small alphabet most of the time so that matches are common
  function automatic logic [CH_W-1:0] pick_char();
    if (narrow_alpha) return char_base + CH_W'($urandom_range(0, 3));
    return CH_W'($urandom_range(0, 255));
  endfunction

  task automatic send_req(req_t kind, logic [CH_W-1:0] c);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    ch        <= c;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(kind, c);
    if (kind != REQ_UNUSED) sent++;
  endtask

  // hold off new requests until every pending result is back
  task automatic wait_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_sequence();
    logic [CH_W-1:0] chars[LCS_MAX_LEN];
    int unsigned     kind, n, m;
    kind         = $urandom_range(0, 99);
    narrow_alpha = ($urandom_range(0, 3) != 0);
    char_base    = CH_W'($urandom_range(0, 255));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, LCS_MAX_LEN) : $urandom_range(1, 8);
    m = $urandom_range(0, 12);
    if (kind < 70) begin
      repeat (n) send_req(REQ_LOAD, pick_char());
      repeat (m) send_req(REQ_CMP, pick_char());
      send_req(REQ_FIN, pick_char());
    end else if (kind < 78) begin
      // same string on both sides, full length now and then for the top value
      if ($urandom_range(0, 3) == 0) n = LCS_MAX_LEN;
      for (int i = 0; i < n; i++) begin
        chars[i] = pick_char();
        send_req(REQ_LOAD, chars[i]);
      end
      for (int i = 0; i < n; i++) send_req(REQ_CMP, chars[i]);
      send_req(REQ_FIN, pick_char());
    end else if (kind < 85) begin
      // store overflow
      repeat (LCS_MAX_LEN + $urandom_range(1, 3)) send_req(REQ_LOAD, pick_char());
      repeat (m) send_req(REQ_CMP, pick_char());
      send_req(REQ_FIN, pick_char());
    end else if (kind < 93) begin
      // loads mixed into compares, stray unused selectors
      repeat ($urandom_range(2, 20)) send_req(req_t'($urandom_range(0, 3)), pick_char());
      send_req(REQ_FIN, pick_char());
    end else begin
      repeat ($urandom_range(1, 6)) send_req(req_t'($urandom_range(0, 3)), pick_char());
    end
  endtask

  initial begin
    int phase;
    phase = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // finish straight after reset, nothing loaded
    send_req(REQ_FIN, 8'h00);
    // extreme chars, unused selector, load after compare
    send_req(REQ_LOAD, 8'h00);
    send_req(REQ_LOAD, 8'hFF);
    send_req(REQ_UNUSED, 8'h5A);
    send_req(REQ_CMP, 8'hFF);
    send_req(REQ_CMP, 8'h00);
    send_req(REQ_LOAD, 8'h55);
    send_req(REQ_FIN, 8'hFF);
    // compares against an empty store
    send_req(REQ_CMP, 8'hAA);
    send_req(REQ_CMP, 8'h55);
    send_req(REQ_FIN, 8'h00);
    // loads but no compares
    send_req(REQ_LOAD, 8'h11);
    send_req(REQ_LOAD, 8'h22);
    send_req(REQ_FIN, 8'h00);

    while (sent < ITEM_TARGET) begin
      if (phase == 0 && sent >= ITEM_TARGET / 3) begin
        wait_drain();
        tx_idle_pct = 52;
        rx_idle_pct = 33;
        phase = 1;
      end else if (phase == 1 && sent >= 2 * ITEM_TARGET / 3) begin
        wait_drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase = 2;
      end
      run_sequence();
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d requests, %0d results checked, %0d of them flagged for misuse",
             sent, sb.checked, sb.flagged);
    $display("run: strings up to %0d chars, idle mixes sender-heavy, receiver-heavy, none",
             LCS_MAX_LEN);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_cell.sv
hw/rtl/lcs_length_engine.sv
hw/rtl/lcs_chk.sv
sim/tb_lcs_length_engine.sv
